// ===== sv/pvr_pkg.sv =====
// shared types, constants and step program of the pivot rotation block
`default_nettype none
package pvr_pkg;

  localparam int TRIG_FRAC_BITS_DEF = 30;
  localparam int CORDIC_STEPS_DEF   = 24;

  localparam int ADDR_W  = 5;
  localparam int ITER_W  = 5;
  localparam int PC_W    = 6;
  localparam int ENTRY_W = 48;
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 33;
  localparam int ACC_W   = 72;

  localparam logic [12:0] ANGLE_FULL   = 13'd5760;
  localparam logic [12:0] ANGLE_Q1     = 13'd1440;
  localparam logic [12:0] ANGLE_Q2     = 13'd2880;
  localparam logic [12:0] ANGLE_Q3     = 13'd4320;
  localparam logic [30:0] ANGLE_STEP   = 31'd1199381129;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [PC_W-1:0] PC_VERT = 6'd24;
  localparam logic [PC_W-1:0] PC_LAST = 6'd35;

  localparam logic [2:0] REG_ANGLE_X = 3'd0;
  localparam logic [2:0] REG_ANGLE_Y = 3'd1;
  localparam logic [2:0] REG_ANGLE_Z = 3'd2;
  localparam logic [2:0] REG_PIVOT_X = 3'd3;
  localparam logic [2:0] REG_PIVOT_Y = 3'd4;
  localparam logic [2:0] REG_PIVOT_Z = 3'd5;

  typedef enum logic [3:0] {
    OA_SX, OA_CX, OA_SY, OA_CY, OA_SZ, OA_CZ, OA_SYX, OA_CYX, OA_M
  } opa_t;

  typedef enum logic [3:0] {
    OB_SX, OB_CX, OB_SY, OB_CY, OB_SZ, OB_CZ, OB_NEG1,
    OB_PX, OB_PY, OB_PZ, OB_VX, OB_VY, OB_VZ, OB_VW
  } opb_t;

  typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} accop_t;
  typedef enum logic [1:0] {RND_NONE, RND_F, RND_16} rnd_t;
  typedef enum logic [2:0] {WR_NONE, WR_SYX, WR_CYX, WR_M, WR_T, WR_TMP, WR_OUT} wr_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TLOAD, ST_TITER, ST_TDONE, ST_PROG, ST_DRAIN, ST_DONE
  } st_t;

  typedef struct packed {
    opa_t       a_sel;
    logic [3:0] a_idx;
    opb_t       b_sel;
    accop_t     acc_op;
    rnd_t       rnd;
    wr_t        wr;
    logic [3:0] w_idx;
  } step_t;

  typedef struct packed {
    logic              latch_in;
    logic              trig_load;
    logic              trig_iter;
    logic              trig_done;
    logic [1:0]        axis;
    logic [ITER_W-1:0] iter;
    logic              step_valid;
    step_t             step;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic [12:0]        angle_x;
    logic [12:0]        angle_y;
    logic [12:0]        angle_z;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] pivot_z;
    logic               stale;
  } cfg_t;

  function automatic logic [29:0] atan_q30(input logic [ITER_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic step_t mk(input opa_t a, input logic [3:0] ai, input opb_t b,
                               input accop_t op, input rnd_t r, input wr_t w,
                               input logic [3:0] wi);
    step_t s;
    s.a_sel  = a;
    s.a_idx  = ai;
    s.b_sel  = b;
    s.acc_op = op;
    s.rnd    = r;
    s.wr     = w;
    s.w_idx  = wi;
    return s;
  endfunction

  // matrix build (0..23) followed by the per-vertex product program (24..35)
  function automatic step_t prog_step(input logic [PC_W-1:0] n);
    step_t s;
    case (n)
      6'd0:  s = mk(OA_SY,  4'd0,  OB_SX,   ACC_LOAD, RND_F,    WR_SYX,  4'd0);
      6'd1:  s = mk(OA_CY,  4'd0,  OB_SX,   ACC_LOAD, RND_F,    WR_CYX,  4'd0);
      6'd2:  s = mk(OA_CY,  4'd0,  OB_CZ,   ACC_LOAD, RND_F,    WR_NONE, 4'd0);
      6'd3:  s = mk(OA_SYX, 4'd0,  OB_SZ,   ACC_ADD,  RND_F,    WR_M,    4'd0);
      6'd4:  s = mk(OA_SYX, 4'd0,  OB_CZ,   ACC_LOAD, RND_F,    WR_NONE, 4'd0);
      6'd5:  s = mk(OA_CY,  4'd0,  OB_SZ,   ACC_SUB,  RND_F,    WR_M,    4'd1);
      6'd6:  s = mk(OA_SY,  4'd0,  OB_CX,   ACC_LOAD, RND_F,    WR_M,    4'd2);
      6'd7:  s = mk(OA_CX,  4'd0,  OB_SZ,   ACC_LOAD, RND_F,    WR_M,    4'd4);
      6'd8:  s = mk(OA_CX,  4'd0,  OB_CZ,   ACC_LOAD, RND_F,    WR_M,    4'd5);
      6'd9:  s = mk(OA_SX,  4'd0,  OB_NEG1, ACC_LOAD, RND_F,    WR_M,    4'd6);
      6'd10: s = mk(OA_CYX, 4'd0,  OB_SZ,   ACC_LOAD, RND_F,    WR_NONE, 4'd0);
      6'd11: s = mk(OA_SY,  4'd0,  OB_CZ,   ACC_SUB,  RND_F,    WR_M,    4'd8);
      6'd12: s = mk(OA_SY,  4'd0,  OB_SZ,   ACC_LOAD, RND_F,    WR_NONE, 4'd0);
      6'd13: s = mk(OA_CYX, 4'd0,  OB_CZ,   ACC_ADD,  RND_F,    WR_M,    4'd9);
      6'd14: s = mk(OA_CY,  4'd0,  OB_CX,   ACC_LOAD, RND_F,    WR_M,    4'd10);
      6'd15: s = mk(OA_M,   4'd0,  OB_PX,   ACC_LOAD, RND_NONE, WR_NONE, 4'd0);
      6'd16: s = mk(OA_M,   4'd1,  OB_PY,   ACC_ADD,  RND_NONE, WR_NONE, 4'd0);
      6'd17: s = mk(OA_M,   4'd2,  OB_PZ,   ACC_ADD,  RND_NONE, WR_T,    4'd3);
      6'd18: s = mk(OA_M,   4'd4,  OB_PX,   ACC_LOAD, RND_NONE, WR_NONE, 4'd0);
      6'd19: s = mk(OA_M,   4'd5,  OB_PY,   ACC_ADD,  RND_NONE, WR_NONE, 4'd0);
      6'd20: s = mk(OA_M,   4'd6,  OB_PZ,   ACC_ADD,  RND_NONE, WR_T,    4'd7);
      6'd21: s = mk(OA_M,   4'd8,  OB_PX,   ACC_LOAD, RND_NONE, WR_NONE, 4'd0);
      6'd22: s = mk(OA_M,   4'd9,  OB_PY,   ACC_ADD,  RND_NONE, WR_NONE, 4'd0);
      6'd23: s = mk(OA_M,   4'd10, OB_PZ,   ACC_ADD,  RND_NONE, WR_T,    4'd11);
      6'd24: s = mk(OA_M,   4'd0,  OB_VX,   ACC_LOAD, RND_NONE, WR_NONE, 4'd0);
      6'd25: s = mk(OA_M,   4'd1,  OB_VY,   ACC_ADD,  RND_NONE, WR_NONE, 4'd0);
      6'd26: s = mk(OA_M,   4'd2,  OB_VZ,   ACC_ADD,  RND_NONE, WR_TMP,  4'd0);
      6'd27: s = mk(OA_M,   4'd3,  OB_VW,   ACC_LOAD, RND_16,   WR_OUT,  4'd0);
      6'd28: s = mk(OA_M,   4'd4,  OB_VX,   ACC_LOAD, RND_NONE, WR_NONE, 4'd0);
      6'd29: s = mk(OA_M,   4'd5,  OB_VY,   ACC_ADD,  RND_NONE, WR_NONE, 4'd0);
      6'd30: s = mk(OA_M,   4'd6,  OB_VZ,   ACC_ADD,  RND_NONE, WR_TMP,  4'd0);
      6'd31: s = mk(OA_M,   4'd7,  OB_VW,   ACC_LOAD, RND_16,   WR_OUT,  4'd1);
      6'd32: s = mk(OA_M,   4'd8,  OB_VX,   ACC_LOAD, RND_NONE, WR_NONE, 4'd0);
      6'd33: s = mk(OA_M,   4'd9,  OB_VY,   ACC_ADD,  RND_NONE, WR_NONE, 4'd0);
      6'd34: s = mk(OA_M,   4'd10, OB_VZ,   ACC_ADD,  RND_NONE, WR_TMP,  4'd0);
      6'd35: s = mk(OA_M,   4'd11, OB_VW,   ACC_LOAD, RND_16,   WR_OUT,  4'd2);
      default: s = mk(OA_SX, 4'd0, OB_SX,   ACC_LOAD, RND_NONE, WR_NONE, 4'd0);
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== sv/pvr_cfg.sv =====
// configuration registers and matrix stale flag
`default_nettype none
module pvr_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pvr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  input  wire logic                        stale_clear,
  output pvr_pkg::cfg_t                    cfg
);

  logic [2:0] idx;
  logic       wr_en;

  assign idx   = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_x <= '0;
      cfg.angle_y <= '0;
      cfg.angle_z <= '0;
      cfg.pivot_x <= '0;
      cfg.pivot_y <= '0;
      cfg.pivot_z <= '0;
      cfg.stale   <= 1'b1;
    end else begin
      if (wr_en) begin
        case (idx)
          pvr_pkg::REG_ANGLE_X: begin
            cfg.angle_x <= pwdata[12:0];
            cfg.stale <= 1'b1;
          end
          pvr_pkg::REG_ANGLE_Y: begin
            cfg.angle_y <= pwdata[12:0];
            cfg.stale <= 1'b1;
          end
          pvr_pkg::REG_ANGLE_Z: begin
            cfg.angle_z <= pwdata[12:0];
            cfg.stale <= 1'b1;
          end
          pvr_pkg::REG_PIVOT_X: begin
            cfg.pivot_x <= pwdata;
            cfg.stale <= 1'b1;
          end
          pvr_pkg::REG_PIVOT_Y: begin
            cfg.pivot_y <= pwdata;
            cfg.stale <= 1'b1;
          end
          pvr_pkg::REG_PIVOT_Z: begin
            cfg.pivot_z <= pwdata;
            cfg.stale <= 1'b1;
          end
          default: begin
          end
        endcase
      end else if (stale_clear) begin
        cfg.stale <= 1'b0;
      end
    end
  end

  always_comb begin
    case (idx)
      pvr_pkg::REG_ANGLE_X: prdata = {19'd0, cfg.angle_x};
      pvr_pkg::REG_ANGLE_Y: prdata = {19'd0, cfg.angle_y};
      pvr_pkg::REG_ANGLE_Z: prdata = {19'd0, cfg.angle_z};
      pvr_pkg::REG_PIVOT_X: prdata = cfg.pivot_x;
      pvr_pkg::REG_PIVOT_Y: prdata = cfg.pivot_y;
      pvr_pkg::REG_PIVOT_Z: prdata = cfg.pivot_z;
      default:              prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/pvr_dp.sv =====
// datapath: cordic unit, shared multiplier, accumulator, matrix and output registers
`default_nettype none
module pvr_dp #(
  parameter int TRIG_FRAC_BITS = pvr_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  pvr_pkg::cfg_t           cfg,
  input  pvr_pkg::cmd_t           cmd,
  input  wire logic signed [31:0] vertex_x,
  input  wire logic signed [31:0] vertex_y,
  input  wire logic signed [31:0] vertex_z,
  input  wire logic signed [31:0] vertex_w,
  output logic signed [31:0]      result_x,
  output logic signed [31:0]      result_y,
  output logic signed [31:0]      result_z,
  output logic signed [31:0]      result_w,
  output logic                    clipped
);

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int SH = 30 - TRIG_FRAC_BITS;
  localparam int AW = pvr_pkg::MUL_A_W;
  localparam int BW = pvr_pkg::MUL_B_W;
  localparam int CW = pvr_pkg::ACC_W;
  localparam int EW = pvr_pkg::ENTRY_W;
  localparam logic signed [33:0] TF_HALF = 34'((64'd1 << SH) >> 1);
  localparam logic signed [33:0] TF_ONE  = 34'sd1 <<< TRIG_FRAC_BITS;
  localparam logic signed [CW-1:0] HALF_F  = 72'sd1 <<< (TRIG_FRAC_BITS - 1);
  localparam logic signed [CW-1:0] HALF_16 = 72'sd32768;
  localparam logic signed [CW-1:0] MAX32   = 72'sd2147483647;
  localparam logic signed [CW-1:0] MIN32   = -72'sd2147483648;

  // trig values and matrix
  logic signed [TW-1:0] sx, cx, sy, cy, sz, cz, syx, cyx;
  logic signed [EW-1:0] m [12];

  // cordic state
  logic signed [32:0] cd_x, cd_y;
  logic signed [33:0] cd_z;
  logic [1:0]         quad;
  logic               rzero;

  // vertex, staging
  logic signed [31:0] vx, vy, vz, vw;
  logic signed [31:0] rx, ry, rz;
  logic [2:0]         clip;
  logic signed [EW-1:0] tmp;

  // multiplier pipe
  logic signed [AW+BW-1:0] prod;
  pvr_pkg::step_t          st_r;
  logic                    sv_r;
  logic signed [CW-1:0]    acc;

  // angle reduction
  logic [12:0] ang, ang_m;
  logic [1:0]  q_new;
  logic [10:0] rem;
  logic [40:0] zprod;

  always_comb begin
    case (cmd.axis)
      2'd0:    ang = cfg.angle_x;
      2'd1:    ang = cfg.angle_y;
      default: ang = cfg.angle_z;
    endcase
    ang_m = (ang >= pvr_pkg::ANGLE_FULL) ? (ang - pvr_pkg::ANGLE_FULL) : ang;
    if (ang_m >= pvr_pkg::ANGLE_Q3) begin
      q_new = 2'd3;
      rem = 11'(ang_m - pvr_pkg::ANGLE_Q3);
    end else if (ang_m >= pvr_pkg::ANGLE_Q2) begin
      q_new = 2'd2;
      rem = 11'(ang_m - pvr_pkg::ANGLE_Q2);
    end else if (ang_m >= pvr_pkg::ANGLE_Q1) begin
      q_new = 2'd1;
      rem = 11'(ang_m - pvr_pkg::ANGLE_Q1);
    end else begin
      q_new = 2'd0;
      rem = ang_m[10:0];
    end
    zprod = {30'd0, rem} * {10'd0, pvr_pkg::ANGLE_STEP} + 41'd512;
  end

  // cordic step
  logic signed [32:0] dx, dy;
  logic signed [33:0] at;

  assign dx = cd_y >>> cmd.iter;
  assign dy = cd_x >>> cmd.iter;
  assign at = {4'd0, pvr_pkg::atan_q30(cmd.iter)};

  // cordic result to trig fraction, quadrant symmetry
  logic signed [33:0] xr, yr;
  logic signed [TW-1:0] c0, s0, cs, sn;

  always_comb begin
    xr = (34'(cd_x) + TF_HALF) >>> SH;
    yr = (34'(cd_y) + TF_HALF) >>> SH;
    if (xr < 0)           c0 = '0;
    else if (xr > TF_ONE) c0 = TF_ONE[TW-1:0];
    else                  c0 = xr[TW-1:0];
    if (yr < 0)           s0 = '0;
    else if (yr > TF_ONE) s0 = TF_ONE[TW-1:0];
    else                  s0 = yr[TW-1:0];
    if (rzero) begin
      c0 = TF_ONE[TW-1:0];
      s0 = '0;
    end
    case (quad)
      2'd0: begin
        cs = c0;
        sn = s0;
      end
      2'd1: begin
        cs = -s0;
        sn = c0;
      end
      2'd2: begin
        cs = -c0;
        sn = -s0;
      end
      default: begin
        cs = s0;
        sn = -c0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.trig_load) begin
      cd_x  <= pvr_pkg::CORDIC_GAIN;
      cd_y  <= '0;
      cd_z  <= {3'd0, zprod[40:10]};
      quad  <= q_new;
      rzero <= (rem == 11'd0);
    end else if (cmd.trig_iter) begin
      if (!cd_z[33]) begin
        cd_x <= cd_x - dx;
        cd_y <= cd_y + dy;
        cd_z <= cd_z - at;
      end else begin
        cd_x <= cd_x + dx;
        cd_y <= cd_y - dy;
        cd_z <= cd_z + at;
      end
    end
    if (cmd.trig_done) begin
      case (cmd.axis)
        2'd0: begin
          sx <= sn;
          cx <= cs;
        end
        2'd1: begin
          sy <= sn;
          cy <= cs;
        end
        default: begin
          sz <= sn;
          cz <= cs;
        end
      endcase
    end
  end

  // operand select
  logic signed [AW-1:0] a_op;
  logic signed [BW-1:0] b_op;

  always_comb begin
    case (cmd.step.a_sel)
      pvr_pkg::OA_SX:  a_op = AW'(sx);
      pvr_pkg::OA_CX:  a_op = AW'(cx);
      pvr_pkg::OA_SY:  a_op = AW'(sy);
      pvr_pkg::OA_CY:  a_op = AW'(cy);
      pvr_pkg::OA_SZ:  a_op = AW'(sz);
      pvr_pkg::OA_CZ:  a_op = AW'(cz);
      pvr_pkg::OA_SYX: a_op = AW'(syx);
      pvr_pkg::OA_CYX: a_op = AW'(cyx);
      default:         a_op = m[cmd.step.a_idx][AW-1:0];
    endcase
    case (cmd.step.b_sel)
      pvr_pkg::OB_SX:   b_op = BW'(sx);
      pvr_pkg::OB_CX:   b_op = BW'(cx);
      pvr_pkg::OB_SY:   b_op = BW'(sy);
      pvr_pkg::OB_CY:   b_op = BW'(cy);
      pvr_pkg::OB_SZ:   b_op = BW'(sz);
      pvr_pkg::OB_CZ:   b_op = BW'(cz);
      pvr_pkg::OB_NEG1: b_op = -(33'sd1 <<< TRIG_FRAC_BITS);
      pvr_pkg::OB_PX:   b_op = BW'(cfg.pivot_x);
      pvr_pkg::OB_PY:   b_op = BW'(cfg.pivot_y);
      pvr_pkg::OB_PZ:   b_op = BW'(cfg.pivot_z);
      pvr_pkg::OB_VX:   b_op = BW'(vx);
      pvr_pkg::OB_VY:   b_op = BW'(vy);
      pvr_pkg::OB_VZ:   b_op = BW'(vz);
      default:          b_op = BW'(vw);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv_r <= 1'b0;
    end else begin
      sv_r <= cmd.step_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_op * b_op;
    st_r <= cmd.step;
  end

  // accumulate and write back
  logic signed [CW-1:0] p72, term, acc_in, acc_next, rf, sum_out, sat;
  logic signed [31:0]   p_sel;
  logic signed [EW-1:0] tval;
  logic                 sat_hit;

  always_comb begin
    p72 = CW'(prod);
    case (st_r.rnd)
      pvr_pkg::RND_F:  term = (p72 + HALF_F) >>> TRIG_FRAC_BITS;
      pvr_pkg::RND_16: term = (p72 + HALF_16) >>> 16;
      default:         term = p72;
    endcase
    acc_in = (st_r.acc_op == pvr_pkg::ACC_LOAD) ? '0 : acc;
    acc_next = (st_r.acc_op == pvr_pkg::ACC_SUB) ? (acc_in - term) : (acc_in + term);
    rf = (acc_next + HALF_F) >>> TRIG_FRAC_BITS;
    case (st_r.w_idx[3:2])
      2'd0:    p_sel = cfg.pivot_x;
      2'd1:    p_sel = cfg.pivot_y;
      default: p_sel = cfg.pivot_z;
    endcase
    tval = EW'(p_sel) - $signed(rf[EW-1:0]);
    sum_out = CW'(tmp) + term;
    sat_hit = 1'b1;
    if (sum_out > MAX32)      sat = MAX32;
    else if (sum_out < MIN32) sat = MIN32;
    else begin
      sat = sum_out;
      sat_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv_r) begin
      acc <= acc_next;
      case (st_r.wr)
        pvr_pkg::WR_SYX: syx <= acc_next[TW-1:0];
        pvr_pkg::WR_CYX: cyx <= acc_next[TW-1:0];
        pvr_pkg::WR_M:   m[st_r.w_idx] <= acc_next[EW-1:0];
        pvr_pkg::WR_T:   m[st_r.w_idx] <= tval;
        pvr_pkg::WR_TMP: tmp <= rf[EW-1:0];
        pvr_pkg::WR_OUT: begin
          clip[st_r.w_idx[1:0]] <= sat_hit;
          case (st_r.w_idx[1:0])
            2'd0:    rx <= sat[31:0];
            2'd1:    ry <= sat[31:0];
            default: rz <= sat[31:0];
          endcase
        end
        default: begin
        end
      endcase
    end
    if (cmd.latch_in) begin
      vx <= vertex_x;
      vy <= vertex_y;
      vz <= vertex_z;
      vw <= vertex_w;
    end
    if (cmd.load_out) begin
      result_x <= rx;
      result_y <= ry;
      result_z <= rz;
      result_w <= vw;
      clipped  <= |clip;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pvr_ctrl.sv =====
// controller: sequences trig evaluation, matrix build and vertex products
`default_nettype none
module pvr_ctrl #(
  parameter int CORDIC_STEPS = pvr_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire logic     stale,
  output logic          stale_clear,
  output pvr_pkg::cmd_t cmd
);

  localparam logic [pvr_pkg::ITER_W-1:0] ITER_LAST = pvr_pkg::ITER_W'(CORDIC_STEPS - 1);

  pvr_pkg::st_t state, state_next;
  logic [1:0]                   axis, axis_next;
  logic [pvr_pkg::ITER_W-1:0]   iter, iter_next;
  logic [pvr_pkg::PC_W-1:0]     pc, pc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pvr_pkg::ST_IDLE;
      axis      <= '0;
      iter      <= '0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      iter  <= iter_next;
      pc    <= pc_next;
      if (cmd.load_out)     out_valid <= 1'b1;
      else if (out_ready)   out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next  = state;
    axis_next   = axis;
    iter_next   = iter;
    pc_next     = pc;
    in_ready    = 1'b0;
    stale_clear = 1'b0;
    cmd         = '0;
    cmd.axis    = axis;
    cmd.iter    = iter;
    cmd.step    = pvr_pkg::prog_step(pc);
    case (state)
      pvr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          if (stale) begin
            stale_clear = 1'b1;
            axis_next   = 2'd0;
            state_next  = pvr_pkg::ST_TLOAD;
          end else begin
            pc_next    = pvr_pkg::PC_VERT;
            state_next = pvr_pkg::ST_PROG;
          end
        end
      end
      pvr_pkg::ST_TLOAD: begin
        cmd.trig_load = 1'b1;
        iter_next     = '0;
        state_next    = pvr_pkg::ST_TITER;
      end
      pvr_pkg::ST_TITER: begin
        cmd.trig_iter = 1'b1;
        if (iter == ITER_LAST) begin
          state_next = pvr_pkg::ST_TDONE;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      pvr_pkg::ST_TDONE: begin
        cmd.trig_done = 1'b1;
        if (axis == 2'd2) begin
          pc_next    = '0;
          state_next = pvr_pkg::ST_PROG;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = pvr_pkg::ST_TLOAD;
        end
      end
      pvr_pkg::ST_PROG: begin
        cmd.step_valid = 1'b1;
        if (pc == pvr_pkg::PC_LAST) begin
          state_next = pvr_pkg::ST_DRAIN;
        end else begin
          pc_next = pc + 1'b1;
        end
      end
      pvr_pkg::ST_DRAIN: begin
        state_next = pvr_pkg::ST_DONE;
      end
      pvr_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = pvr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pvr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/pivot_rotation_vertex_3d_top.sv =====
// top level of the pivot rotation block: apb registers, controller, datapath
// with a current matrix an accepted item runs the 12 steps of the shared multiplier (3 rows,
// 4 products each), drain and output load (held off by an unread result); no new item until then
// after a register write the next item first runs cordic per axis and the matrix build program
// synchronous active-high reset clears control, marks the matrix stale; no clearing pass
`default_nettype none
module pivot_rotation_vertex_3d_top #(
  parameter int TRIG_FRAC_BITS = pvr_pkg::TRIG_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS   = pvr_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pvr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // vertex item in
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [31:0]         vertex_x,
  input  wire logic signed [31:0]         vertex_y,
  input  wire logic signed [31:0]         vertex_z,
  input  wire logic signed [31:0]         vertex_w,
  // result item out
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [31:0]              result_x,
  output logic signed [31:0]              result_y,
  output logic signed [31:0]              result_z,
  output logic signed [31:0]              result_w,
  output logic                            clipped
);

  pvr_pkg::cfg_t cfg;
  pvr_pkg::cmd_t cmd;
  logic          stale_clear;

  // register writes complete in the access phase with no wait states
  assign pready = 1'b1;

  // angle and pivot registers; any write to one of them marks the matrix for a rebuild
  pvr_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .stale_clear (stale_clear),
    .cfg         (cfg)
  );

  // sequencer: when the matrix is stale, cordic per axis and build program; then vertex program
  pvr_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stale       (cfg.stale),
    .stale_clear (stale_clear),
    .cmd         (cmd)
  );

  // cordic, one registered multiplier with accumulator, 3x4 matrix, output item register
  pvr_dp #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .vertex_x (vertex_x),
    .vertex_y (vertex_y),
    .vertex_z (vertex_z),
    .vertex_w (vertex_w),
    .result_x (result_x),
    .result_y (result_y),
    .result_z (result_z),
    .result_w (result_w),
    .clipped  (clipped)
  );

endmodule
`default_nettype wire

// ===== sim/pivot_rotation_vertex_3d_top_tb.sv =====
// self-checking testbench for the pivot rotation block: apb setup, random vertex stream
`timescale 1ns / 1ps
`default_nettype none
module pivot_rotation_vertex_3d_top_tb;

  localparam int FRAC = pvr_pkg::TRIG_FRAC_BITS_DEF;
  localparam int STEPS = pvr_pkg::CORDIC_STEPS_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               clip;
  } rotated_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [pvr_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] vertex_x = '0, vertex_y = '0, vertex_z = '0, vertex_w = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] result_x, result_y, result_z, result_w;
  logic clipped;

  pivot_rotation_vertex_3d_top dut (.*);

  always #4 clk = ~clk;

  // predictor copy of the register file and the matrix
  logic [12:0] ang_x_q, ang_y_q, ang_z_q;
  logic signed [31:0] piv_x_q, piv_y_q, piv_z_q;
  longint matrix_q[12];
  bit matrix_fresh;

  vertex_t  pending_vertices[$];
  rotated_t expected_results[$];
  int errors = 0;
  bit stim_done = 0;
  bit no_idle = 0;       // long stretch without idling on either side
  int quiet_cycles = 0;
  bit in_accepted = 0;

  longint atan_tab[30] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  // rounding half up then arithmetic shift
  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_frac(longint v);
    longint one;
    one = longint'(1) << FRAC;
    v = rnd_shift(v, (FRAC < 30) ? 30 - FRAC : 0);
    if (v < 0) v = 0;
    if (v > one) v = one;
    return v;
  endfunction

  // cordic sine/cosine of an angle in sixteenths of a degree
  task automatic sin_cos(input logic [12:0] ang, output longint sn, output longint cs);
    longint a, r, c0, s0, x, y, z, dx, dy;
    int quad;
    a = longint'(ang) % 5760;
    quad = int'(a / 1440);
    r = a % 1440;
    if (r == 0) begin
      c0 = longint'(1) << FRAC;
      s0 = 0;
    end else begin
      x = 652032874;
      y = 0;
      z = (r * 1199381129 + 512) >>> 10;
      for (int i = 0; i < STEPS && i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      c0 = clamp_frac(x);
      s0 = clamp_frac(y);
    end
    case (quad)
      0: begin cs = c0;  sn = s0;  end
      1: begin cs = -s0; sn = c0;  end
      2: begin cs = -c0; sn = -s0; end
      default: begin cs = s0; sn = -c0; end
    endcase
  endtask

  function automatic longint qmul(longint a, longint b);
    return rnd_shift(a * b, FRAC);
  endfunction

  task automatic build_matrix();
    longint sx, cx, sy, cy, sz, cz, syx, cyx, acc;
    longint p[3];
    sin_cos(ang_x_q, sx, cx);
    sin_cos(ang_y_q, sy, cy);
    sin_cos(ang_z_q, sz, cz);
    syx = qmul(sy, sx);
    cyx = qmul(cy, sx);
    matrix_q[0] = qmul(cy, cz) + qmul(syx, sz);
    matrix_q[1] = qmul(syx, cz) - qmul(cy, sz);
    matrix_q[2] = qmul(sy, cx);
    matrix_q[4] = qmul(cx, sz);
    matrix_q[5] = qmul(cx, cz);
    matrix_q[6] = -sx;
    matrix_q[8] = qmul(cyx, sz) - qmul(sy, cz);
    matrix_q[9] = qmul(sy, sz) + qmul(cyx, cz);
    matrix_q[10] = qmul(cy, cx);
    p[0] = piv_x_q; p[1] = piv_y_q; p[2] = piv_z_q;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += matrix_q[i*4+j] * p[j];
      matrix_q[i*4+3] = p[i] - rnd_shift(acc, FRAC);
    end
    matrix_fresh = 1;
  endtask

  // expected rotated vertex; the product r*v fits in 64 bits (|r|<=2^31, |v|<=2^31)
  function automatic rotated_t rotate_vertex(vertex_t v);
    rotated_t res;
    longint vv[3], wv, wh, wl, acc, t, r;
    logic signed [31:0] outc[3];
    vv[0] = v.x; vv[1] = v.y; vv[2] = v.z;
    wv = v.w;
    wh = wv >>> 16;
    wl = wv - wh * 65536;
    res.clip = 0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      t = matrix_q[i*4+3];
      for (int j = 0; j < 3; j++) acc += matrix_q[i*4+j] * vv[j];
      r = rnd_shift(acc, FRAC) + t * wh + ((t * wl + 32768) >>> 16);
      if (r > 64'sd2147483647) begin r = 64'sd2147483647; res.clip = 1; end
      if (r < -64'sd2147483648) begin r = -64'sd2147483648; res.clip = 1; end
      outc[i] = r[31:0];
    end
    res.x = outc[0]; res.y = outc[1]; res.z = outc[2];
    res.w = v.w;
    return res;
  endfunction

  // apb write: setup then access, inputs moved on falling edges
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= pvr_pkg::ADDR_W'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      pvr_pkg::REG_ANGLE_X: ang_x_q = val[12:0];
      pvr_pkg::REG_ANGLE_Y: ang_y_q = val[12:0];
      pvr_pkg::REG_ANGLE_Z: ang_z_q = val[12:0];
      pvr_pkg::REG_PIVOT_X: piv_x_q = val;
      pvr_pkg::REG_PIVOT_Y: piv_y_q = val;
      pvr_pkg::REG_PIVOT_Z: piv_z_q = val;
      default: ;
    endcase
    matrix_fresh = 0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $urandom_range(0, 32'h01FFFFFF) - 32'h01000000;
    endcase
  endfunction

  function automatic logic [12:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 13'd0;
      1: return 13'd1440 * 13'($urandom_range(1, 5));
      2: return 13'd8191;
      3: return 13'd5759;
      default: return 13'($urandom);
    endcase
  endfunction

  // queue a vertex and predict its result at once, in order
  task automatic push_vertex(input vertex_t v);
    if (!matrix_fresh) build_matrix();
    pending_vertices.push_back(v);
    expected_results.push_back(rotate_vertex(v));
  endtask

  // let the block drain before touching registers again
  task automatic wait_drained();
    while (pending_vertices.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    vertex_t v;
    for (int i = 0; i < n; i++) begin
      v.x = rand_coord(); v.y = rand_coord(); v.z = rand_coord();
      case ($urandom_range(0, 3))
        0: v.w = rand_coord();
        1: v.w = 32'h00000000;
        default: v.w = 32'h00010000;   // usual unit weight
      endcase
      push_vertex(v);
    end
  endtask

  // stimulus sequencer
  initial begin
    vertex_t v;
    ang_x_q = 0; ang_y_q = 0; ang_z_q = 0;
    piv_x_q = 0; piv_y_q = 0; piv_z_q = 0;
    foreach (matrix_q[i]) matrix_q[i] = 0;
    matrix_fresh = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: identity after reset, field extremes
    v = '{32'h00010000, 32'h00020000, 32'hFFFD0000, 32'h00010000}; push_vertex(v);
    v = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000}; push_vertex(v);
    v = '{32'hFFFFFFFF, 32'h00000000, 32'h80000000, 32'h7FFFFFFF}; push_vertex(v);
    wait_drained();
    // quarter turns, pivot far out so results saturate
    reg_write(pvr_pkg::REG_ANGLE_X, 32'd1440);
    reg_write(pvr_pkg::REG_ANGLE_Y, 32'd2880);
    reg_write(pvr_pkg::REG_ANGLE_Z, 32'd4320);
    reg_write(pvr_pkg::REG_PIVOT_X, 32'h7FFFFFFF);
    reg_write(pvr_pkg::REG_PIVOT_Y, 32'h80000000);
    reg_write(pvr_pkg::REG_PIVOT_Z, 32'h40000000);
    v = '{32'h80000000, 32'h7FFFFFFF, 32'h00000000, 32'h00010000}; push_vertex(v);
    v = '{32'h00000000, 32'h00000000, 32'h00000000, 32'h7FFFFFFF}; push_vertex(v);
    v = '{32'h12345678, 32'hEDCBA987, 32'h00000001, 32'h80000000}; push_vertex(v);
    wait_drained();
    // angles past 5759 wrap; odd angles exercise cordic; same-value rewrite
    reg_write(pvr_pkg::REG_ANGLE_X, 32'hFFFFFFFF);
    reg_write(pvr_pkg::REG_ANGLE_Y, 32'd5759);
    reg_write(pvr_pkg::REG_ANGLE_Z, 32'd1);
    reg_write(pvr_pkg::REG_PIVOT_X, 32'd0);
    reg_write(pvr_pkg::REG_PIVOT_Y, 32'hFFFF0000);
    reg_write(pvr_pkg::REG_PIVOT_Z, 32'h80000000);
    v = '{32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000}; push_vertex(v);
    v = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF}; push_vertex(v);
    wait_drained();
    reg_write(pvr_pkg::REG_PIVOT_X, 32'd0);    // rewrite same value: matrix rebuilt anyway
    reg_write(3'd6, 32'h12345678);     // unmapped register is ignored
    v = '{32'h00030000, 32'hFFFF8000, 32'h00000000, 32'h00010000}; push_vertex(v);
    wait_drained();

    // random phases, each with a fresh register setting
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) no_idle = 1;
      if (ph == 6) no_idle = 0;
      reg_write(pvr_pkg::REG_ANGLE_X, 32'(rand_angle()));
      reg_write(pvr_pkg::REG_ANGLE_Y, 32'(rand_angle()));
      reg_write(pvr_pkg::REG_ANGLE_Z, 32'(rand_angle()));
      reg_write(pvr_pkg::REG_PIVOT_X, rand_coord());
      reg_write(pvr_pkg::REG_PIVOT_Y, rand_coord());
      reg_write(pvr_pkg::REG_PIVOT_Z, rand_coord());
      random_phase(50);
      wait_drained();
    end
    stim_done = 1;
  end

  // driver: offers the next pending vertex, changes only at falling edges
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_accepted) begin
      // hold until accepted
    end else if (pending_vertices.size() != 0 && (no_idle || $urandom_range(0, 99) >= 35)) begin
      in_valid <= 1'b1;
      vertex_x <= pending_vertices[0].x;
      vertex_y <= pending_vertices[0].y;
      vertex_z <= pending_vertices[0].z;
      vertex_w <= pending_vertices[0].w;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    out_ready <= !rst && (no_idle || $urandom_range(0, 99) >= 35);
  end

  // accept tracking and checks on rising edges
  always @(posedge clk) begin
    rotated_t exp_r;
    in_accepted <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        void'(pending_vertices.pop_front());
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_x !== exp_r.x) begin
            $error("result_x expected %0d got %0d", exp_r.x, result_x); errors++;
          end
          if (result_y !== exp_r.y) begin
            $error("result_y expected %0d got %0d", exp_r.y, result_y); errors++;
          end
          if (result_z !== exp_r.z) begin
            $error("result_z expected %0d got %0d", exp_r.z, result_z); errors++;
          end
          if (result_w !== exp_r.w) begin
            $error("result_w expected %0d got %0d", exp_r.w, result_w); errors++;
          end
          if (clipped !== exp_r.clip) begin
            $error("clipped expected %0d got %0d", exp_r.clip, clipped); errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted item or register access, and the final verdict
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (stim_done) begin
      if (errors == 0 && expected_results.size() == 0)
        $display("TB_OK");
      else
        $display("TB_ERROR");
      $finish;
    end
  end

endmodule
`default_nettype wire

// ===== pivot_rotation_vertex_3d_top.f =====
sv/pvr_pkg.sv
sv/pvr_cfg.sv
sv/pvr_dp.sv
sv/pvr_ctrl.sv
sv/pivot_rotation_vertex_3d_top.sv
sim/pivot_rotation_vertex_3d_top_tb.sv
